@@ sv/sxg_pkg.sv @@
// Shared types and constants for the horizontal Sobel gradient block.
// Used by the top level, its checker and the testbench; depends on nothing else.
`default_nettype none

package sxg_pkg;

   // Item field widths
   localparam int PIXEL_W     = 8;
   localparam int GRAD_W      = 11;
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 16;

   // Largest gradient magnitude the kernel can give on 8-bit pixels
   localparam int GRAD_MAX = 1020;

   // Register file
   localparam int CFG_W      = 11;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic [CFG_W-1:0] SIDE_RESET = 11'd64;

   // Register index, taken from the word address bit
   localparam logic CSR_IMAGE_SIDE = 1'b0;

   typedef logic        [PIXEL_W-1:0] pixel_type;
   typedef logic signed [GRAD_W-1:0]  grad_type;

   // Kind of an input item, carried on tuser
   typedef enum logic {
      REQ_PIXEL = 1'b0,
      REQ_FLUSH = 1'b1
   } req_kind_type;

endpackage : sxg_pkg

`default_nettype wire

@@ sv/sobel_x_gradient_3x3.sv @@
// Horizontal 3x3 Sobel gradient over a raster-order stream of square images.
// Depends on sxg_pkg for widths, item kinds and register codes.
//
//  Channel  | Direction | Carries
//  ---------+-----------+-----------------------------------------------
//  req_     | in        | tdata: pixel; tuser: item kind (pixel/flush)
//  rsp_     | out       | tdata: gradient (signed); tlast: frame end
//  csr_     | in/out    | APB-style register port, image_side at 0x0
//
// One item is taken every cycle unless a stalled result holds the item stage; an
// accepted item loads the item stage and reads the line store, and its result
// is offered once it moves on into the result register. Results lag the pixel
// stream by one row plus one pixel; flush items drain the trailing side+1 results.
// Reset is synchronous; the line stores are not cleared.
// A stalled result register holds the item stage, which holds req_tready low.
`default_nettype none

module sobel_x_gradient_3x3 #(
   parameter int MAX_SIDE = 1024
) (
   input  wire                               clock,
   input  wire                               reset,
   // input items
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire  [sxg_pkg::REQ_TDATA_W-1:0]   req_tdata,   // [7:0] pixel
   input  wire  [0:0]                        req_tuser,   // [0] req_type
   // result items
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [sxg_pkg::RSP_TDATA_W-1:0]   rsp_tdata,   // [10:0] gradient, [15:11] zero
   output logic                              rsp_tlast,   // frame_last
   // register port
   input  wire                               csr_psel,
   input  wire                               csr_penable,
   input  wire                               csr_pwrite,
   input  wire  [sxg_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire  [sxg_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [sxg_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   localparam int COL_W  = $clog2(MAX_SIDE);
   localparam int SIDE_W = $clog2(MAX_SIDE + 1);
   localparam int EXT_W  = sxg_pkg::GRAD_W + 1;
   localparam int LINE_W = 2 * sxg_pkg::PIXEL_W;
   // reset side, clamped to the store depth like a written one
   localparam int SIDE_RESET_USED = (int'(sxg_pkg::SIDE_RESET) > MAX_SIDE) ?
                                    MAX_SIDE : int'(sxg_pkg::SIDE_RESET);

   // ---------------------------------------------------------------
   // Register port
   // ---------------------------------------------------------------
   logic                       cfg_write;
   logic [sxg_pkg::CFG_W-1:0]  side_raw_ff, side_raw_in;
   logic [SIDE_W-1:0]          side_ff, side_in;

   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == sxg_pkg::CSR_IMAGE_SIDE);
   assign csr_prdata = (csr_paddr[2] == sxg_pkg::CSR_IMAGE_SIDE) ?
                       sxg_pkg::CSR_DATA_W'(side_raw_ff) : '0;

   // clamp the written side to 1..MAX_SIDE
   always_comb begin
      side_raw_in = side_raw_ff;
      side_in     = side_ff;
      if (cfg_write) begin
         side_raw_in = csr_pwdata[sxg_pkg::CFG_W-1:0];
         if (side_raw_in == '0) begin
            side_in = SIDE_W'(1);
         end else if (int'(side_raw_in) > MAX_SIDE) begin
            side_in = SIDE_W'(MAX_SIDE);
         end else begin
            side_in = SIDE_W'(side_raw_in);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_raw_ff <= sxg_pkg::SIDE_RESET;
         side_ff     <= SIDE_W'(SIDE_RESET_USED);
      end else begin
         side_raw_ff <= side_raw_in;
         side_ff     <= side_in;
      end
   end

   logic [SIDE_W-1:0] side_m1, side_m2;
   assign side_m1 = side_ff - SIDE_W'(1);
   assign side_m2 = side_ff - SIDE_W'(2);

   // ---------------------------------------------------------------
   // Accept stage: position counters and result bookkeeping
   // ---------------------------------------------------------------
   logic [COL_W-1:0]  in_col_ff, in_col_in;
   logic [SIDE_W-1:0] in_row_ff, in_row_in;
   logic [COL_W-1:0]  res_col_ff, res_col_in;
   logic [COL_W-1:0]  res_row_ff, res_row_in;

   logic accept, in_done, is_flush, take_pixel, pix_emit, emit;
   logic res_last, res_interior, restart;

   // item stage registers
   logic                    b_valid_ff, b_valid_in;
   logic                    b_write_ff, b_emit_ff, b_interior_ff, b_last_ff, b_restart_ff;
   sxg_pkg::pixel_type      b_pixel_ff;
   logic [COL_W-1:0]        b_col_ff;
   logic                    b_adv;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   sxg_pkg::grad_type       rsp_grad_ff;
   logic                    rsp_last_ff;
   logic                    out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign b_adv      = b_valid_ff && (!b_emit_ff || out_free);
   assign req_tready = !b_valid_ff || b_adv;
   assign accept     = req_tvalid && req_tready;

   assign in_done    = (in_row_ff == side_ff);
   assign is_flush   = (req_tuser[0] == sxg_pkg::REQ_FLUSH);
   assign take_pixel = !in_done && !is_flush;
   assign pix_emit   = (in_row_ff > SIDE_W'(1)) ||
                       ((in_row_ff == SIDE_W'(1)) && (in_col_ff != '0));
   assign emit       = in_done || (take_pixel && pix_emit);

   assign res_last   = (SIDE_W'(res_row_ff) == side_m1) && (SIDE_W'(res_col_ff) == side_m1);
   assign res_interior = (side_ff >= SIDE_W'(3)) &&
                         (res_row_ff != '0) && (SIDE_W'(res_row_ff) <= side_m2) &&
                         (res_col_ff != '0) && (SIDE_W'(res_col_ff) <= side_m2);
   assign restart    = emit && res_last;

   // next positions
   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      res_col_in = res_col_ff;
      res_row_in = res_row_ff;
      if (cfg_write) begin
         in_col_in  = '0;
         in_row_in  = '0;
         res_col_in = '0;
         res_row_in = '0;
      end else if (accept) begin
         if (take_pixel) begin
            if (SIDE_W'(in_col_ff) == side_m1) begin
               in_col_in = '0;
               in_row_in = in_row_ff + SIDE_W'(1);
            end else begin
               in_col_in = in_col_ff + COL_W'(1);
            end
         end
         if (emit) begin
            if (SIDE_W'(res_col_ff) == side_m1) begin
               res_col_in = '0;
               res_row_in = res_row_ff + COL_W'(1);
            end else begin
               res_col_in = res_col_ff + COL_W'(1);
            end
         end
         // frame complete: start over
         if (restart) begin
            in_col_in  = '0;
            in_row_in  = '0;
            res_col_in = '0;
            res_row_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         res_col_ff <= '0;
         res_row_ff <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         res_col_ff <= res_col_in;
         res_row_ff <= res_row_in;
      end
   end

   // ---------------------------------------------------------------
   // Item stage: ignored flushes never enter
   // ---------------------------------------------------------------
   always_comb begin
      b_valid_in = b_valid_ff;
      if (cfg_write) begin
         b_valid_in = 1'b0;
      end else if (accept) begin
         b_valid_in = take_pixel || emit;
      end else if (b_adv) begin
         b_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_write_ff    <= take_pixel;
         b_emit_ff     <= emit;
         b_interior_ff <= res_interior;
         b_last_ff     <= res_last;
         b_restart_ff  <= restart;
         b_pixel_ff    <= req_tdata[sxg_pkg::PIXEL_W-1:0];
         b_col_ff      <= in_col_ff;
      end
   end

   // ---------------------------------------------------------------
   // Line stores: upper row in the high byte, lower row in the low byte
   // ---------------------------------------------------------------
   logic [LINE_W-1:0] line_mem [MAX_SIDE];
   logic [LINE_W-1:0] rd_data_ff;
   logic [LINE_W-1:0] fwd_data_ff;
   logic              fwd_ff;
   logic [LINE_W-1:0] line_word, wr_word;
   logic              mem_write;

   sxg_pkg::pixel_type t0, t1, m0, m1, b0;

   assign line_word = fwd_ff ? fwd_data_ff : rd_data_ff;
   assign t1        = line_word[LINE_W-1:sxg_pkg::PIXEL_W];
   assign m1        = line_word[sxg_pkg::PIXEL_W-1:0];
   assign wr_word   = {m1, b_pixel_ff};
   assign mem_write = b_adv && b_write_ff;

   always_ff @(posedge clock) begin
      if (mem_write) begin
         line_mem[b_col_ff] <= wr_word;
      end
      if (accept) begin
         rd_data_ff <= line_mem[in_col_ff];
      end
   end

   // bypass when the read lands on the entry being written (side of one)
   always_ff @(posedge clock) begin
      if (accept) begin
         fwd_ff      <= mem_write && (b_col_ff == in_col_ff);
         fwd_data_ff <= wr_word;
      end
   end

   // ---------------------------------------------------------------
   // Window: rows top, middle, bottom; column 0 is the older one
   // ---------------------------------------------------------------
   sxg_pkg::pixel_type win_ff [3][2];

   assign t0 = win_ff[0][0];
   assign m0 = win_ff[1][0];
   assign b0 = win_ff[2][0];

   always_ff @(posedge clock) begin
      if (reset || cfg_write || (b_adv && b_restart_ff)) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= '0;
            win_ff[r][1] <= '0;
         end
      end else if (mem_write) begin
         win_ff[0][0] <= win_ff[0][1];
         win_ff[0][1] <= t1;
         win_ff[1][0] <= win_ff[1][1];
         win_ff[1][1] <= m1;
         win_ff[2][0] <= win_ff[2][1];
         win_ff[2][1] <= b_pixel_ff;
      end
   end

   // ---------------------------------------------------------------
   // Kernel: (t1 - t0) + 2 (m1 - m0) + (b1 - b0)
   // ---------------------------------------------------------------
   logic signed [EXT_W-1:0] d_top, d_mid, d_bot, g_sum;
   sxg_pkg::grad_type       grad;

   assign d_top = $signed({{(EXT_W-sxg_pkg::PIXEL_W){1'b0}}, t1})
                - $signed({{(EXT_W-sxg_pkg::PIXEL_W){1'b0}}, t0});
   assign d_mid = $signed({{(EXT_W-sxg_pkg::PIXEL_W){1'b0}}, m1})
                - $signed({{(EXT_W-sxg_pkg::PIXEL_W){1'b0}}, m0});
   assign d_bot = $signed({{(EXT_W-sxg_pkg::PIXEL_W){1'b0}}, b_pixel_ff})
                - $signed({{(EXT_W-sxg_pkg::PIXEL_W){1'b0}}, b0});
   assign g_sum = d_top + (d_mid <<< 1) + d_bot;
   assign grad  = (b_write_ff && b_interior_ff) ? g_sum[sxg_pkg::GRAD_W-1:0] : '0;

   // ---------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (b_adv && b_emit_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_adv && b_emit_ff) begin
         rsp_grad_ff <= grad;
         rsp_last_ff <= b_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = sxg_pkg::RSP_TDATA_W'($unsigned(rsp_grad_ff));
   assign rsp_tlast  = rsp_last_ff;

endmodule : sobel_x_gradient_3x3

`default_nettype wire

@@ sv/sxg_checker.sv @@
// Port-level checks for sobel_x_gradient_3x3, attached by the bind below.
// Depends on sxg_pkg for the gradient width and range.
`default_nettype none

module sxg_checker (
   input wire                             clock,
   input wire                             reset,
   input wire                             rsp_tvalid,
   input wire                             rsp_tready,
   input wire [sxg_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input wire                             rsp_tlast
);

   // a result waiting on the sink stays offered
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // and keeps its payload
   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result payload changed while stalled");

   // the final result of a frame is a border pixel
   a_last_border : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[sxg_pkg::GRAD_W-1:0] == '0)
      else $error("frame end carries a non-zero gradient");

   // gradient within kernel range, padding clear
   a_grad_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[sxg_pkg::GRAD_W-1:0]) >= -sxg_pkg::GRAD_MAX) &&
                     ($signed(rsp_tdata[sxg_pkg::GRAD_W-1:0]) <= sxg_pkg::GRAD_MAX) &&
                     (rsp_tdata[sxg_pkg::RSP_TDATA_W-1:sxg_pkg::GRAD_W] == '0))
      else $error("gradient out of range");

   // nothing is offered straight after reset
   a_reset_quiet : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered after reset");

endmodule : sxg_checker

bind sobel_x_gradient_3x3 sxg_checker u_sxg_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

@@ dv/sobel_x_gradient_3x3_tb.sv @@
// Self-checking testbench for the horizontal 3x3 Sobel gradient block.
// Drives pixel/flush items and APB register writes, predicts every result.
// Depends on sxg_pkg and sobel_x_gradient_3x3 only.

module sobel_x_gradient_3x3_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_SIDE     = 1024;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES  = 300;
   localparam int CYCLE_LIMIT  = 500_000;
   localparam int RANDOM_ITEMS = 760;
   localparam logic [sxg_pkg::CSR_ADDR_W-1:0] SIDE_ADDR = {sxg_pkg::CSR_IMAGE_SIDE, 2'b00};

   typedef struct packed {
      sxg_pkg::req_kind_type kind;
      sxg_pkg::pixel_type    pixel;
   } stream_item_type;

   typedef struct packed {
      logic              valid;
      sxg_pkg::grad_type grad;
      logic              last;
   } sobel_result_type;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_MOSTLY,
      READY_HALF,
      READY_ALTERNATE
   } ready_mode_type;

   // DUT connections
   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [sxg_pkg::REQ_TDATA_W-1:0]  req_tdata = '0;    // [7:0] pixel
   logic [0:0]                       req_tuser = '0;    // [0] req_type
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [sxg_pkg::RSP_TDATA_W-1:0]  rsp_tdata;         // [10:0] gradient, [15:11] zero
   logic                             rsp_tlast;
   logic                             csr_psel = 1'b0;
   logic                             csr_penable = 1'b0;
   logic                             csr_pwrite = 1'b0;
   logic [sxg_pkg::CSR_ADDR_W-1:0]   csr_paddr = '0;
   logic [sxg_pkg::CSR_DATA_W-1:0]   csr_pwdata = '0;
   logic [sxg_pkg::CSR_DATA_W-1:0]   csr_prdata;
   logic                             csr_pready;

   // Stimulus and checking state
   stream_item_type  item_queue [$];
   sobel_result_type gradient_queue [$];
   bit               req_taken = 1'b0;
   int               error_count = 0;
   int               results_checked = 0;
   int               stream_items = 0;
   int               cycle_count = 0;
   int               gap_left = 0;
   int               burst_left = 0;
   bit               hold_armed = 1'b0;
   bit               hold_done = 1'b0;
   int               hold_left = 0;
   int               mode_left = 0;
   ready_mode_type   stall_mode = READY_ALWAYS;

   // Predictor state
   sxg_pkg::pixel_type        upper_line [MAX_SIDE];
   sxg_pkg::pixel_type        lower_line [MAX_SIDE];
   sxg_pkg::pixel_type        window_px [3][2];
   logic [sxg_pkg::CFG_W-1:0] side_reg;
   int                        in_col;
   int                        in_row;
   int                        emitted;

   sobel_x_gradient_3x3 #(.MAX_SIDE(MAX_SIDE)) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Gradient predictor
   // ---------------------------------------------------------------------

   // Side in use: zero runs as one, anything past the store depth is capped
   function automatic int clamp_side(logic [sxg_pkg::CFG_W-1:0] raw);
      if (raw == '0) return 1;
      if (raw > MAX_SIDE) return MAX_SIDE;
      return int'(raw);
   endfunction

   function automatic void restart_frame();
      for (int r = 0; r < 3; r++) begin
         window_px[r][0] = '0;
         window_px[r][1] = '0;
      end
      in_col  = 0;
      in_row  = 0;
      emitted = 0;
   endfunction

   function automatic sobel_result_type emit_gradient(int side, int grad);
      sobel_result_type r;
      r.valid = 1'b1;
      r.grad  = grad[sxg_pkg::GRAD_W-1:0];
      r.last  = (emitted == side * side - 1);
      emitted++;
      if (emitted >= side * side) restart_frame();
      return r;
   endfunction

   function automatic sobel_result_type sobel_predict(sxg_pkg::req_kind_type kind,
                                                      sxg_pkg::pixel_type pix);
      sobel_result_type r;
      int side, n, ry, cx, t0, t1, m0, m1, b0, grad;
      r = '0;
      side = clamp_side(side_reg);
      // whole frame taken in: any item drains one border result
      if (in_row >= side) return emit_gradient(side, 0);
      if (kind == sxg_pkg::REQ_FLUSH) return r;

      n  = in_row * side + in_col;
      t0 = window_px[0][0];
      t1 = upper_line[in_col];
      m0 = window_px[1][0];
      m1 = lower_line[in_col];
      b0 = window_px[2][0];
      grad = (t1 - t0) + 2 * (m1 - m0) + (int'(pix) - b0);

      // shift the window and the two line stores
      window_px[0][0] = window_px[0][1];
      window_px[0][1] = sxg_pkg::pixel_type'(t1);
      window_px[1][0] = window_px[1][1];
      window_px[1][1] = sxg_pkg::pixel_type'(m1);
      window_px[2][0] = window_px[2][1];
      window_px[2][1] = pix;
      upper_line[in_col] = sxg_pkg::pixel_type'(m1);
      lower_line[in_col] = pix;

      in_col++;
      if (in_col >= side) begin
         in_col = 0;
         in_row++;
      end

      // nothing out until one row plus one pixel is in
      if (n < side + 1) return r;
      ry = emitted / side;
      cx = emitted % side;
      if (!(side >= 3 && ry >= 1 && ry + 2 <= side && cx >= 1 && cx + 2 <= side)) grad = 0;
      return emit_gradient(side, grad);
   endfunction

   // ---------------------------------------------------------------------
   // Monitor: register writes, accepted items and results, all at the edge
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      sobel_result_type  res;
      sxg_pkg::grad_type got;
      sxg_pkg::grad_type want;
      if (reset) begin
         for (int i = 0; i < MAX_SIDE; i++) begin
            upper_line[i] = '0;
            lower_line[i] = '0;
         end
         side_reg  = sxg_pkg::SIDE_RESET;
         restart_frame();
         req_taken = 1'b0;
      end else begin
         // any side write restarts the frame
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == SIDE_ADDR) begin
            side_reg = csr_pwdata[sxg_pkg::CFG_W-1:0];
            restart_frame();
         end

         req_taken = req_tvalid && req_tready;
         if (req_taken) begin
            void'(item_queue.pop_front());
            res = sobel_predict(sxg_pkg::req_kind_type'(req_tuser[0]),
                                req_tdata[sxg_pkg::PIXEL_W-1:0]);
            if (res.valid) gradient_queue.push_back(res);
         end

         if (rsp_tvalid && rsp_tready) begin
            results_checked++;
            got = rsp_tdata[sxg_pkg::GRAD_W-1:0];
            if (gradient_queue.size() == 0) begin
               $error("unexpected result: gradient %0d, tlast %0b", got, rsp_tlast);
               error_count++;
            end else begin
               res  = gradient_queue.pop_front();
               want = res.grad;
               if (got !== want) begin
                  $error("gradient: expected %0d, actual %0d", want, got);
                  error_count++;
               end
               if (rsp_tdata[sxg_pkg::RSP_TDATA_W-1:sxg_pkg::GRAD_W] !== '0) begin
                  $error("tdata pad: expected 0, actual %0h",
                         rsp_tdata[sxg_pkg::RSP_TDATA_W-1:sxg_pkg::GRAD_W]);
                  error_count++;
               end
               if (rsp_tlast !== res.last) begin
                  $error("frame_last: expected %0b, actual %0b", res.last, rsp_tlast);
                  error_count++;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Item driver: bursts of random length with random gaps
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_taken) begin
         // hold the offered item until it is taken
      end else if (gap_left > 0 || item_queue.size() == 0) begin
         if (gap_left > 0) gap_left--;
         req_tvalid <= 1'b0;
      end else begin
         req_tvalid <= 1'b1;
         req_tdata  <= item_queue[0].pixel;
         req_tuser  <= item_queue[0].kind;
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(1, 32);
            gap_left   = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 6);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result receiver: stall pattern changes every so often; one long
   // hold-off once the final small frame starts giving results
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (hold_armed && !hold_done && rsp_tvalid) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (mode_left == 0) begin
            stall_mode = ready_mode_type'($urandom_range(3));
            mode_left  = $urandom_range(30, 200);
         end else begin
            mode_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (stall_mode)
               READY_ALWAYS:    rsp_tready <= 1'b1;
               READY_MOSTLY:    rsp_tready <= ($urandom_range(3) != 0);
               READY_HALF:      rsp_tready <= 1'($urandom_range(1));
               READY_ALTERNATE: rsp_tready <= ~rsp_tready;
            endcase
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic csr_transfer(bit write, logic [sxg_pkg::CSR_DATA_W-1:0] wdata,
                               output logic [sxg_pkg::CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= SIDE_ADDR;
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic csr_write(logic [sxg_pkg::CSR_DATA_W-1:0] data);
      logic [sxg_pkg::CSR_DATA_W-1:0] unused;
      csr_transfer(1'b1, data, unused);
   endtask

   task automatic csr_check(logic [sxg_pkg::CFG_W-1:0] expected);
      logic [sxg_pkg::CSR_DATA_W-1:0] rdata;
      csr_transfer(1'b0, '0, rdata);
      if (rdata !== sxg_pkg::CSR_DATA_W'(expected)) begin
         $error("image_side readback: expected %0d, actual %0d", expected, rdata);
         error_count++;
      end
   endtask

   task automatic push_item(sxg_pkg::req_kind_type kind, sxg_pkg::pixel_type pix);
      stream_item_type it;
      it.kind  = kind;
      it.pixel = pix;
      item_queue.push_back(it);
   endtask

   // One frame of pixels with stray flushes mixed in; a complete frame gets
   // its drain tail, where some of the draining items are pixels
   task automatic queue_frame(int side, int pixels, bit extremes);
      int tail;
      tail = 0;
      for (int i = 0; i < pixels; i++) begin
         if ($urandom_range(9) == 0) push_item(sxg_pkg::REQ_FLUSH, sxg_pkg::pixel_type'($urandom));
         if (extremes) push_item(sxg_pkg::REQ_PIXEL, ($urandom_range(1) != 0) ? 8'hFF : 8'h00);
         else push_item(sxg_pkg::REQ_PIXEL, sxg_pkg::pixel_type'($urandom));
      end
      if (pixels == side * side) begin
         tail = (side == 1) ? 1 : side + 1;
         repeat (tail) push_item(($urandom_range(9) < 7) ? sxg_pkg::REQ_FLUSH : sxg_pkg::REQ_PIXEL,
                                 sxg_pkg::pixel_type'($urandom));
      end
      stream_items += pixels + tail;
   endtask

   // Block idle: everything sent, every result in, pipeline given time to empty
   task automatic wait_drained();
      while (item_queue.size() != 0 || req_tvalid || gradient_queue.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      sxg_pkg::pixel_type             ramp_up [9];
      sxg_pkg::pixel_type             ramp_down [9];
      logic [sxg_pkg::CFG_W-1:0]      raw;
      logic [sxg_pkg::CSR_DATA_W-1:0] wdata;
      int                             frames, side, sent;

      ramp_up   = '{8'h00, 8'h80, 8'hFF, 8'h00, 8'h4D, 8'hFF, 8'h00, 8'hC8, 8'hFF};
      ramp_down = '{8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h01, 8'h00};

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      csr_check(sxg_pkg::SIDE_RESET);

      // Smallest side with an interior pixel: largest positive gradient,
      // a flush before the frame is in is ignored, flushes drain the tail
      csr_write(32'd3);
      csr_check(11'd3);
      foreach (ramp_up[i]) begin
         if (i == 6) push_item(sxg_pkg::REQ_FLUSH, 8'hFF);
         push_item(sxg_pkg::REQ_PIXEL, ramp_up[i]);
      end
      repeat (4) push_item(sxg_pkg::REQ_FLUSH, 8'h00);
      wait_drained();

      // Most negative gradient; pixels after the frame act as drain items
      foreach (ramp_down[i]) push_item(sxg_pkg::REQ_PIXEL, ramp_down[i]);
      repeat (4) push_item(sxg_pkg::REQ_PIXEL, sxg_pkg::pixel_type'($urandom));
      wait_drained();

      // Side zero runs as a single-pixel image
      csr_write(32'd0);
      csr_check(11'd0);
      push_item(sxg_pkg::REQ_PIXEL, 8'hFF);
      push_item(sxg_pkg::REQ_FLUSH, 8'h00);
      wait_drained();

      // Random phases: mostly small sides, frames back to back, some cut short
      while (stream_items < RANDOM_ITEMS) begin
         case ($urandom_range(9))
            0:             raw = '0;
            1:             raw = sxg_pkg::CFG_W'($urandom_range(1, 2));
            2, 3, 4, 5, 6: raw = sxg_pkg::CFG_W'($urandom_range(3, 8));
            7, 8:          raw = sxg_pkg::CFG_W'($urandom_range(9, 16));
            default:       raw = sxg_pkg::CFG_W'($urandom_range(17, 28));
         endcase
         wdata = $urandom;
         wdata[sxg_pkg::CFG_W-1:0] = raw;
         csr_write(wdata);
         if ($urandom_range(3) == 0) csr_check(raw);
         side   = clamp_side(raw);
         frames = $urandom_range(1, 3);
         for (int f = 0; f < frames; f++) begin
            sent = side * side;
            if (f == frames - 1 && $urandom_range(4) == 0) sent = $urandom_range(0, sent - 1);
            // keep the random phases within the item budget
            if (sent > RANDOM_ITEMS - stream_items)
               sent = (stream_items < RANDOM_ITEMS) ? RANDOM_ITEMS - stream_items : 0;
            queue_frame(side, sent, $urandom_range(3) == 0);
         end
         wait_drained();
      end

      // Widest image: all-ones is capped to the store depth; a short start
      // of a frame, then a restart by a second write of the same side
      csr_write(32'hFFFF_FFFF);
      csr_check(11'h7FF);
      queue_frame(MAX_SIDE, 40, 1'b0);
      wait_drained();

      csr_write(sxg_pkg::CSR_DATA_W'(MAX_SIDE));
      csr_check(sxg_pkg::CFG_W'(MAX_SIDE));
      queue_frame(MAX_SIDE, 40, 1'b1);
      wait_drained();

      // Back to a small side after a cut-short frame, one full frame. The
      // receiver holds off here so the block backs up into its input.
      csr_write(32'd5);
      hold_armed <= 1'b1;
      queue_frame(5, 25, 1'b0);
      wait_drained();

      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
